/* hdl/cdlm_pkg.sv */
// ----------------------------------------------------------------------------
// cdlm_pkg
// Shared types and constants for the card-detect link manager.
// ----------------------------------------------------------------------------
`default_nettype none

package cdlm_pkg;

   localparam int TIMER_W    = 10;
   localparam int TRIES_W    = 3;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
   localparam logic [TRIES_W-1:0] RETRY_MAX = '1;

   localparam logic [TIMER_W-1:0] DEBOUNCE_TICKS_RST = 10'd50;
   localparam logic [TIMER_W-1:0] CONNECT_DELAY_RST  = 10'd100;
   localparam logic [TRIES_W-1:0] MAX_TRIES_RST      = 3'd3;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DEBOUNCE_TICKS = 2'd0,
      CSR_CONNECT_DELAY  = 2'd1,
      CSR_MAX_TRIES      = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      LINK_IDLE         = 3'd0,
      LINK_CONNECTING   = 3'd1,
      LINK_CONNECTED    = 3'd2,
      LINK_DISCONNECTED = 3'd3,
      LINK_ERROR        = 3'd4
   } link_state_type;

   typedef enum logic [1:0] {
      EV_NONE         = 2'd0,
      EV_CONNECTED    = 2'd1,
      EV_DISCONNECTED = 2'd2
   } event_code_type;

   typedef struct packed {
      logic [TIMER_W-1:0] connect_delay_ticks;
      logic [TRIES_W-1:0] max_tries;
   } link_cfg_type;

   typedef struct packed {
      link_state_type link_state;
      event_code_type event_code;
      logic           init_attempt;
      logic           card_present;
   } result_type;

endpackage

`default_nettype wire

/* hdl/cdlm_req_if.sv */
// ----------------------------------------------------------------------------
// cdlm_req_if
// Tick channel: raw card-detect pin and init outcome.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdlm_req_if;
   logic valid;
   logic ready;
   logic pin_level;
   logic init_ok;

   modport source (output valid, output pin_level, output init_ok, input ready);
   modport sink   (input valid, input pin_level, input init_ok, output ready);
endinterface

`default_nettype wire

/* hdl/cdlm_rsp_if.sv */
// ----------------------------------------------------------------------------
// cdlm_rsp_if
// Result channel: link state, event and debounced presence.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdlm_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] link_state;
   logic [1:0] event_code;
   logic       init_attempt;
   logic       card_present;

   modport source (output valid, output link_state, output event_code,
                   output init_attempt, output card_present, input ready);
   modport sink   (input valid, input link_state, input event_code,
                   input init_attempt, input card_present, output ready);
endinterface

`default_nettype wire

/* hdl/cdlm_csr_if.sv */
// ----------------------------------------------------------------------------
// cdlm_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdlm_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] addr;
   logic [9:0] wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

/* hdl/cdlm_debounce.sv */
// ----------------------------------------------------------------------------
// cdlm_debounce
// Card-detect debouncer: first change taken at once, later ones after a hold.
// ----------------------------------------------------------------------------
`default_nettype none

module cdlm_debounce (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        tick,
   input  wire logic                        raw_present,
   input  wire logic [cdlm_pkg::TIMER_W-1:0] debounce_ticks,
   output logic                             present
);
   import cdlm_pkg::*;

   logic               stable_ff, stable_in;
   logic               seen_ff, seen_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;

   always_comb begin
      stable_in = stable_ff;
      seen_in   = seen_ff;
      timer_in  = timer_ff;
      if (raw_present == stable_ff) begin
         timer_in = '0;
      end else begin
         timer_in = (timer_ff == TIMER_MAX) ? TIMER_MAX : timer_ff + 1'b1;
         // timer is left running after a change is taken
         if ((timer_in > debounce_ticks) || !seen_ff) begin
            seen_in   = 1'b1;
            stable_in = raw_present;
         end
      end
   end

   assign present = stable_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= 1'b0;
         seen_ff   <= 1'b0;
         timer_ff  <= '0;
      end else if (tick) begin
         stable_ff <= stable_in;
         seen_ff   <= seen_in;
         timer_ff  <= timer_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/cdlm_link_fsm.sv */
// ----------------------------------------------------------------------------
// cdlm_link_fsm
// Five-state link manager with connect delay and init retry limit.
// ----------------------------------------------------------------------------
`default_nettype none

module cdlm_link_fsm (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   tick,
   input  wire logic                   present,
   input  wire logic                   init_ok,
   input  wire cdlm_pkg::link_cfg_type cfg,
   output cdlm_pkg::result_type        result
);
   import cdlm_pkg::*;

   link_state_type     state_ff, state_in;
   logic [TIMER_W-1:0] ctimer_ff, ctimer_in;
   logic [TRIES_W-1:0] retry_ff, retry_in;
   logic               ready_ff, ready_in;

   logic [TIMER_W-1:0] ctimer_inc;
   logic [TRIES_W-1:0] retry_inc;
   logic               fire;
   event_code_type     event_code;
   logic               attempt;

   assign ctimer_inc = (ctimer_ff == TIMER_MAX) ? TIMER_MAX : ctimer_ff + 1'b1;
   assign retry_inc  = (retry_ff == RETRY_MAX) ? RETRY_MAX : retry_ff + 1'b1;
   assign fire       = (ctimer_inc >= cfg.connect_delay_ticks);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         LINK_CONNECTING: begin
            if (fire) begin
               if (init_ok) begin
                  state_in = LINK_CONNECTED;
               end else begin
                  state_in = (retry_inc >= cfg.max_tries) ? LINK_ERROR : LINK_IDLE;
               end
            end
         end
         LINK_CONNECTED: begin
            if (!present) state_in = LINK_IDLE;
         end
         LINK_DISCONNECTED, LINK_ERROR: begin
            if (present) state_in = LINK_IDLE;
         end
         default: begin
            if (present) begin
               state_in = ready_ff ? LINK_CONNECTED : LINK_CONNECTING;
            end else if (ready_ff) begin
               state_in = LINK_DISCONNECTED;
            end else begin
               state_in = LINK_IDLE;
            end
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      event_code = EV_NONE;
      attempt    = 1'b0;
      ctimer_in  = ctimer_ff;
      retry_in   = retry_ff;
      ready_in   = ready_ff;
      case (state_ff)
         LINK_CONNECTING: begin
            ctimer_in = ctimer_inc;
            if (fire) begin
               attempt  = 1'b1;
               ready_in = init_ok;
               if (init_ok) begin
                  event_code = EV_CONNECTED;
                  retry_in   = '0;
               end else begin
                  retry_in = retry_inc;
               end
            end
         end
         LINK_CONNECTED: begin
            if (!present) begin
               ready_in   = 1'b0;
               retry_in   = '0;
               event_code = EV_DISCONNECTED;
            end
         end
         LINK_DISCONNECTED, LINK_ERROR: begin
            if (present) retry_in = '0;
         end
         default: begin
            if (present) begin
               if (!ready_ff) ctimer_in = '0;
            end else if (ready_ff) begin
               ready_in   = 1'b0;
               event_code = EV_DISCONNECTED;
            end
         end
      endcase
   end

   assign result.link_state   = state_in;
   assign result.event_code   = event_code;
   assign result.init_attempt = attempt;
   assign result.card_present = present;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= LINK_IDLE;
         ctimer_ff <= '0;
         retry_ff  <= '0;
         ready_ff  <= 1'b0;
      end else if (tick) begin
         state_ff  <= state_in;
         ctimer_ff <= ctimer_in;
         retry_ff  <= retry_in;
         ready_ff  <= ready_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/cdlm_out_buf.sv */
// ----------------------------------------------------------------------------
// cdlm_out_buf
// Result register with a skid entry behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module cdlm_out_buf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire cdlm_pkg::result_type in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output cdlm_pkg::result_type      out_data
);
   import cdlm_pkg::*;

   logic       main_vld_ff, main_vld_in;
   logic       skid_vld_ff, skid_vld_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign in_ready  = !skid_vld_ff;
   assign out_valid = main_vld_ff;
   assign out_data  = main_ff;
   assign pop       = main_vld_ff && out_ready;

   always_comb begin
      main_vld_in = main_vld_ff;
      skid_vld_in = skid_vld_ff;
      main_in     = main_ff;
      skid_in     = skid_ff;
      if (skid_vld_ff) begin
         if (pop) begin
            main_in     = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (!main_vld_ff || pop) begin
         main_vld_in = in_valid;
         main_in     = in_data;
      end else if (in_valid) begin
         skid_vld_in = 1'b1;
         skid_in     = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         main_vld_ff <= main_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

/* hdl/card_detect_link_manager_top.sv */
// ----------------------------------------------------------------------------
// card_detect_link_manager_top
// Card-detect debouncer and SD link manager, one transfer per millisecond tick.
// ----------------------------------------------------------------------------
// usage
//   req_ch : one transfer per tick with the raw active-low pin and init_ok
//   rsp_ch : one transfer per tick with link state, event, attempt flag and
//            debounced presence, in tick order
//   csr_ch : register writes (0 debounce ticks, 1 connect delay, 2 max
//            tries), always ready, only while no tick is in flight
// output   : each result is registered; it waits in the skid entry while one is held
// rate     : one tick per cycle while req_ch.ready is high; debounce and link
//            update are a single combinational step on the state registers
// stall    : the result register plus one skid entry let a tick be taken
//            while a result waits; req_ch.ready drops only once both hold
// reset    : synchronous; link idle, no card, counters clear, registers
//            back to 50 / 100 / 3, result buffer empty
// ----------------------------------------------------------------------------
`default_nettype none

module card_detect_link_manager_top (
   input  wire logic  clock,
   input  wire logic  reset,
   cdlm_req_if.sink   req_ch,
   cdlm_rsp_if.source rsp_ch,
   cdlm_csr_if.sink   csr_ch
);
   import cdlm_pkg::*;

   // configuration registers
   logic [TIMER_W-1:0] dbnc_ticks_ff;
   logic [TIMER_W-1:0] conn_delay_ff;
   logic [TRIES_W-1:0] max_tries_ff;

   logic         tick;        // input transfer this cycle
   logic         present;     // debounced presence after this tick
   link_cfg_type link_cfg;
   result_type   step_result;
   result_type   out_data;
   logic         buf_ready;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dbnc_ticks_ff <= DEBOUNCE_TICKS_RST;
         conn_delay_ff <= CONNECT_DELAY_RST;
         max_tries_ff  <= MAX_TRIES_RST;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.addr))
            CSR_DEBOUNCE_TICKS: dbnc_ticks_ff <= csr_ch.wdata[TIMER_W-1:0];
            CSR_CONNECT_DELAY:  conn_delay_ff <= csr_ch.wdata[TIMER_W-1:0];
            CSR_MAX_TRIES:      max_tries_ff  <= csr_ch.wdata[TRIES_W-1:0];
            default: ;          // unmapped index, write dropped
         endcase
      end
   end

   assign req_ch.ready = buf_ready;
   assign tick         = req_ch.valid && buf_ready;

   assign link_cfg.connect_delay_ticks = conn_delay_ff;
   assign link_cfg.max_tries           = max_tries_ff;

   // pin is active low: 0 means a card sits in the slot
   cdlm_debounce u_debounce (
      .clock          (clock),
      .reset          (reset),
      .tick           (tick),
      .raw_present    (!req_ch.pin_level),
      .debounce_ticks (dbnc_ticks_ff),
      .present        (present)
   );

   cdlm_link_fsm u_link_fsm (
      .clock   (clock),
      .reset   (reset),
      .tick    (tick),
      .present (present),
      .init_ok (req_ch.init_ok),
      .cfg     (link_cfg),
      .result  (step_result)
   );

   cdlm_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tick),
      .in_ready  (buf_ready),
      .in_data   (step_result),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (out_data)
   );

   assign rsp_ch.link_state   = out_data.link_state;
   assign rsp_ch.event_code   = out_data.event_code;
   assign rsp_ch.init_attempt = out_data.init_attempt;
   assign rsp_ch.card_present = out_data.card_present;

   // a refused tick means a result is waiting
   a_ready_low_has_result: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> rsp_ch.valid)
      else $error("input refused with no result pending");

   // an attempt always leaves connecting
   a_attempt_leaves_connecting: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.init_attempt |->
         (rsp_ch.link_state == LINK_CONNECTED) || (rsp_ch.link_state == LINK_IDLE) ||
         (rsp_ch.link_state == LINK_ERROR))
      else $error("init attempt reported outside a connect outcome");

   // connected event only with a successful attempt
   a_connect_event: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.event_code == EV_CONNECTED) |->
         rsp_ch.init_attempt && (rsp_ch.link_state == LINK_CONNECTED))
      else $error("connect event without successful attempt");

   // disconnect event only when the card has gone
   a_disconnect_event: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && (rsp_ch.event_code == EV_DISCONNECTED) |->
         !rsp_ch.card_present && ((rsp_ch.link_state == LINK_IDLE) ||
         (rsp_ch.link_state == LINK_DISCONNECTED)))
      else $error("disconnect event with card present");

endmodule

`default_nettype wire

/* dv/tb_card_detect_link_manager_top.sv */
// ----------------------------------------------------------------------------
// tb_card_detect_link_manager_top
// Self-checking bench for the card-detect debouncer and link manager. Ticks
// are sent as pin runs of random length around the debounce and connect
// windows, with random init outcomes. Each result transfer is checked against
// a cycle model held in a small scoreboard class. Register settings and
// handshake idling change from phase to phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_card_detect_link_manager_top;
   import cdlm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SHOW_LIMIT  = 10;

   // scoreboard: tracks the debouncer and link state, queues expected results
   class link_checker;
      logic [TIMER_W-1:0] cfg_debounce;
      logic [TIMER_W-1:0] cfg_delay;
      logic [TRIES_W-1:0] cfg_tries;
      logic               level_q;
      logic               seen_q;
      logic [TIMER_W-1:0] deb_timer;
      logic [TIMER_W-1:0] wait_timer;
      link_state_type     mode_q;
      logic [TRIES_W-1:0] fail_count;
      logic               card_ok;
      result_type         pending_results[$];
      int                 mismatches;
      int                 results_seen;

      function new();
         cfg_debounce = DEBOUNCE_TICKS_RST;
         cfg_delay    = CONNECT_DELAY_RST;
         cfg_tries    = MAX_TRIES_RST;
         level_q      = 1'b0;
         seen_q       = 1'b0;
         deb_timer    = '0;
         wait_timer   = '0;
         mode_q       = LINK_IDLE;
         fail_count   = '0;
         card_ok      = 1'b0;
         mismatches   = 0;
         results_seen = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_DEBOUNCE_TICKS: cfg_debounce = val;
            CSR_CONNECT_DELAY:  cfg_delay    = val;
            CSR_MAX_TRIES:      cfg_tries    = val[TRIES_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_tick(logic pin, logic ok);
         result_type exp;
         logic       raw;
         raw              = ~pin;
         exp.event_code   = EV_NONE;
         exp.init_attempt = 1'b0;
         // debounce: first change taken at once, later ones after the window
         if (raw == level_q) begin
            deb_timer = '0;
         end else begin
            if (deb_timer != TIMER_MAX) deb_timer = deb_timer + 1'b1;
            if (deb_timer > cfg_debounce || !seen_q) begin
               seen_q  = 1'b1;
               level_q = raw;
            end
         end
         case (mode_q)
            LINK_CONNECTING: begin
               if (wait_timer != TIMER_MAX) wait_timer = wait_timer + 1'b1;
               if (wait_timer >= cfg_delay) begin
                  exp.init_attempt = 1'b1;
                  card_ok          = ok;
                  if (ok) begin
                     mode_q         = LINK_CONNECTED;
                     exp.event_code = EV_CONNECTED;
                     fail_count     = '0;
                  end else begin
                     if (fail_count != RETRY_MAX) fail_count = fail_count + 1'b1;
                     mode_q = (fail_count >= cfg_tries) ? LINK_ERROR : LINK_IDLE;
                  end
               end
            end
            LINK_CONNECTED: begin
               if (!level_q) begin
                  card_ok        = 1'b0;
                  fail_count     = '0;
                  mode_q         = LINK_IDLE;
                  exp.event_code = EV_DISCONNECTED;
               end
            end
            LINK_DISCONNECTED, LINK_ERROR: begin
               if (level_q) begin
                  fail_count = '0;
                  mode_q     = LINK_IDLE;
               end
            end
            default: begin
               if (level_q) begin
                  if (card_ok) begin
                     mode_q = LINK_CONNECTED;
                  end else begin
                     mode_q     = LINK_CONNECTING;
                     wait_timer = '0;
                  end
               end else if (card_ok) begin
                  card_ok        = 1'b0;
                  mode_q         = LINK_DISCONNECTED;
                  exp.event_code = EV_DISCONNECTED;
               end else begin
                  mode_q = LINK_IDLE;
               end
            end
         endcase
         exp.link_state   = mode_q;
         exp.card_present = level_q;
         pending_results.push_back(exp);
      endfunction

      function void check_result(result_type act);
         result_type exp;
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
               $display("result with no tick pending: state %0d event %0d attempt %0d present %0d",
                        act.link_state, act.event_code, act.init_attempt, act.card_present);
         end else begin
            exp = pending_results.pop_front();
            if (act.link_state !== exp.link_state || act.event_code !== exp.event_code ||
                act.init_attempt !== exp.init_attempt ||
                act.card_present !== exp.card_present) begin
               mismatches++;
               if (mismatches <= SHOW_LIMIT)
                  $display("result %0d mismatch: exp state %0d event %0d attempt %0d present %0d,%s",
                           results_seen, exp.link_state, exp.event_code, exp.init_attempt,
                           exp.card_present, " got");
               if (mismatches <= SHOW_LIMIT)
                  $display("   got state %0d event %0d attempt %0d present %0d",
                           act.link_state, act.event_code, act.init_attempt,
                           act.card_present);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   cdlm_req_if req_ch();
   cdlm_rsp_if rsp_ch();
   cdlm_csr_if csr_ch();

   card_detect_link_manager_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   link_checker links = new();

   int         cycle_count  = 0;
   int         ticks_sent   = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   logic       run_pin      = 1'b1;
   int         run_left     = 0;
   result_type rsp_word;

   always #4 clock = ~clock;

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side back-pressure, one draw per cycle
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: register writes, accepted ticks and result transfers
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready)
            links.set_register(csr_index_type'(csr_ch.addr), csr_ch.wdata);
         if (req_ch.valid && req_ch.ready)
            links.note_tick(req_ch.pin_level, req_ch.init_ok);
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_word.link_state   = link_state_type'(rsp_ch.link_state);
            rsp_word.event_code   = event_code_type'(rsp_ch.event_code);
            rsp_word.init_attempt = rsp_ch.init_attempt;
            rsp_word.card_present = rsp_ch.card_present;
            links.check_result(rsp_word);
         end
      end
   end

   // one tick transfer, with a random gap in front of it
   task automatic send_tick(input logic pin, input logic ok);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.pin_level <= pin;
      req_ch.init_ok   <= ok;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      ticks_sent++;
   endtask

   // stop sending and wait until every tick has its result back
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (links.results_seen < ticks_sent) @(posedge clock);
   endtask

   task automatic csr_put(input csr_index_type idx, input int val);
      csr_ch.valid <= 1'b1;
      csr_ch.addr  <= idx;
      csr_ch.wdata <= val[CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   // write all three registers back to back, only while nothing is in flight
   task automatic program_link(input int deb, input int dly, input int tries_word);
      drain();
      csr_put(CSR_DEBOUNCE_TICKS, deb);
      csr_put(CSR_CONNECT_DELAY, dly);
      csr_put(CSR_MAX_TRIES, tries_word);
      csr_ch.valid <= 1'b0;
   endtask

   // idling: 0 none, 1 sender gaps, 2 receiver stalls, 3 both
   task automatic set_idling(input int mode);
      case (mode)
         1:       begin send_idle_pct = 67; recv_stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  recv_stall_pct = 67; end
         3:       begin send_idle_pct = 35; recv_stall_pct = 35; end
         default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
   endtask

   // pin runs: a quarter end at most one tick past the window (mostly glitches),
   // the rest long enough to be taken, most also letting the connect delay run out
   task automatic run_phase(input int deb, input int dly, input int tries_word,
                            input int count, input int ok_pct, input int mode);
      int upper;
      program_link(deb, dly, tries_word);
      set_idling(mode);
      upper = 2 * deb + 3 * dly + 10;
      if (upper > 1500) upper = 1500;
      for (int i = 0; i < count; i++) begin
         if (run_left == 0) begin
            run_pin = ~run_pin;
            if ($urandom_range(3) == 0)
               run_left = $urandom_range(deb + 1, 1);
            else
               run_left = $urandom_range(upper, deb + 1);
         end
         run_left--;
         send_tick(run_pin, $urandom_range(99) < ok_pct);
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.pin_level = 1'b1;
      req_ch.init_ok   = 1'b0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.addr      = CSR_DEBOUNCE_TICKS;
      csr_ch.wdata     = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset registers: no card, then the first change taken at once,
      // then a short glitch that the 50-tick window must swallow
      send_tick(1'b1, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);

      // zero window, zero delay, zero tries: first failure goes to error,
      // presence leaves error, success connects, card loss disconnects
      program_link(0, 0, 0);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      // presence ignored while connecting: card pulled at the attempt
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b1);

      // random phases: window, delay, tries word, ticks, success %, idling
      run_phase(3,    2,    1,     100, 60, 0);
      run_phase(0,    0,    7,     90,  20, 1);
      run_phase(1,    5,    2,     100, 40, 2);
      run_phase(8,    1,    7,     100, 15, 3);
      run_phase(2,    400,  7,     550, 50, 0);
      // max window, tries written with the unused upper bits set
      run_phase(1023, 4,    10'h3FD, 75, 50, 1);
      run_phase(5,    3,    3,     100, 35, 3);
      run_phase(1,    1,    1,     75,  50, 2);

      drain();
      repeat (4) @(posedge clock);
      if (links.pending_results.size() != 0) begin
         links.mismatches++;
         $display("%0d expected results never arrived", links.pending_results.size());
      end
      if (links.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
